FILE: rtl/sdbt_pkg.sv
// Shared types and constants for the SD SPI block transfer engine.
`default_nettype none

package sdbt_pkg;

  localparam logic [9:0]  BLOCK_BYTES     = 10'd512;
  localparam logic [19:0] RESP_POLL_LIMIT = 20'd512;
  localparam logic [19:0] POLL_MAX        = 20'hFFFFF;
  localparam logic [2:0]  FRAME_BYTES     = 3'd6;

  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] TOKEN_SINGLE   = 8'hFE;
  localparam logic [7:0] TOKEN_MULTI    = 8'hFC;
  localparam logic [7:0] TOKEN_STOP     = 8'hFD;
  localparam logic [7:0] CMD_PREFIX     = 8'h40;
  localparam logic [7:0] DRESP_MASK     = 8'h1F;
  localparam logic [7:0] DRESP_ACCEPTED = 8'h05;

  localparam logic [5:0] CMD12 = 6'd12;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD18 = 6'd18;
  localparam logic [5:0] CMD23 = 6'd23;
  localparam logic [5:0] CMD24 = 6'd24;
  localparam logic [5:0] CMD25 = 6'd25;

  localparam logic [7:0] CRC_SINGLE = 8'h01;
  localparam logic [7:0] CRC_MULTI  = 8'hFF;
  localparam logic [7:0] CRC_SETCNT = 8'h00;

  typedef enum logic [1:0] {
    CFG_CARD_TYPE = 2'd0,
    CFG_READY_TO  = 2'd1,
    CFG_TOKEN_TO  = 2'd2,
    CFG_BUSY_TO   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CT_MMC    = 2'd0,
    CT_SD1    = 2'd1,
    CT_SD2_SC = 2'd2,
    CT_SD2_HC = 2'd3
  } card_type_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_CMD_REJ  = 3'd2,
    ST_DATA_REJ = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    K_MAIN     = 2'd0,
    K_SETCOUNT = 2'd1,
    K_STOP     = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    FS_SELECT = 2'd0,
    FS_READY  = 2'd1,
    FS_FRAME  = 2'd2,
    FS_R1     = 2'd3
  } frame_stage_e;

  // Command phases are laid out as four stages per command kind.
  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_MAIN_SEL    = 5'd1,
    PH_MAIN_READY  = 5'd2,
    PH_MAIN_FRAME  = 5'd3,
    PH_MAIN_R1     = 5'd4,
    PH_SETC_SEL    = 5'd5,
    PH_SETC_READY  = 5'd6,
    PH_SETC_FRAME  = 5'd7,
    PH_SETC_R1     = 5'd8,
    PH_STOP_SEL    = 5'd9,
    PH_STOP_READY  = 5'd10,
    PH_STOP_FRAME  = 5'd11,
    PH_STOP_R1     = 5'd12,
    PH_RD_TOKEN    = 5'd13,
    PH_RD_DATA     = 5'd14,
    PH_RD_CRC      = 5'd15,
    PH_WR_FILL     = 5'd16,
    PH_WR_TOKEN    = 5'd17,
    PH_WR_DATA     = 5'd18,
    PH_WR_CRC      = 5'd19,
    PH_WR_RESP     = 5'd20,
    PH_WR_BUSY     = 5'd21,
    PH_WR_STOP     = 5'd22,
    PH_WR_STOPWAIT = 5'd23,
    PH_TAIL        = 5'd24
  } phase_e;

  typedef struct packed {
    card_type_e  card_type;
    logic [19:0] ready_timeout;
    logic [19:0] token_timeout;
    logic [15:0] busy_timeout;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic        write_request;
    logic [31:0] block_addr;
    logic [7:0]  block_count;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] mosi_byte;
    logic       chip_select_n;
    logic       payload_request;
    logic       read_valid;
    logic [7:0] read_byte;
    status_e    status;
    logic       done_res;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/sdbt_cfg_regs.sv
// Configuration register file of the SD SPI block transfer engine.
`default_nettype none

module sdbt_cfg_regs
  import sdbt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CARD_TYPE: cfg_d.card_type     = card_type_e'(cfg_data_i[1:0]);
        CFG_READY_TO:  cfg_d.ready_timeout = cfg_data_i;
        CFG_TOKEN_TO:  cfg_d.token_timeout = cfg_data_i;
        CFG_BUSY_TO:   cfg_d.busy_timeout  = cfg_data_i[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_type     <= CT_MMC;
      cfg_q.ready_timeout <= 20'hFFFFF;
      cfg_q.token_timeout <= 20'hFFFFF;
      cfg_q.busy_timeout  <= 16'hFFFE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/sdbt_seq.sv
// Transfer sequencer: phase state and the per-exchange decision logic.
`default_nettype none

module sdbt_seq
  import sdbt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output res_t          res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  frame_q, frame_d;
  logic [9:0]  bytepos_q, bytepos_d;
  logic [7:0]  blocks_q, blocks_d;
  logic [19:0] poll_q, poll_d;
  logic [31:0] card_addr_q, card_addr_d;
  logic        writing_q, writing_d;
  logic        multi_q, multi_d;

  logic [19:0]  poll_inc;
  logic [9:0]   bytepos_inc;
  logic [2:0]   frame_inc;
  logic [7:0]   blocks_dec;
  logic [3:0]   cmd_off;
  cmd_kind_e    kind;
  frame_stage_e stage;
  logic         r1_seen;
  logic         multi_new;
  logic [7:0]   miso;

  function automatic res_t xfer(input logic [7:0] mosi, input logic csn);
    res_t r;
    r = '0;
    r.send_valid    = 1'b1;
    r.mosi_byte     = mosi;
    r.chip_select_n = csn;
    r.status        = ST_BUSY;
    return r;
  endfunction

  function automatic res_t finish(input status_e st);
    res_t r;
    r = '0;
    r.chip_select_n = 1'b1;
    r.status        = st;
    r.done_res      = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(input cmd_kind_e k, input logic [2:0] pos,
                                            input logic wr, input logic mul,
                                            input logic [7:0] cnt, input logic [31:0] addr);
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    case (k)
      K_SETCOUNT: begin
        cmd = CMD23;
        arg = {24'd0, cnt};
        crc = CRC_SETCNT;
      end
      K_STOP: begin
        cmd = CMD12;
        arg = 32'd0;
        crc = CRC_MULTI;
      end
      default: begin
        if (wr) begin
          cmd = mul ? CMD25 : CMD24;
        end else begin
          cmd = mul ? CMD18 : CMD17;
        end
        crc = mul ? CRC_MULTI : CRC_SINGLE;
        arg = addr;
      end
    endcase
    case (pos)
      3'd0:    b = CMD_PREFIX | {2'b00, cmd};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  assign miso        = item_i.miso_byte;
  assign poll_inc    = (poll_q != POLL_MAX) ? poll_q + 20'd1 : poll_q;
  assign bytepos_inc = bytepos_q + 10'd1;
  assign frame_inc   = frame_q + 3'd1;
  assign blocks_dec  = (blocks_q != 8'd0) ? blocks_q - 8'd1 : blocks_q;
  assign cmd_off     = phase_q[3:0] - 4'd1;
  assign kind        = cmd_kind_e'(cmd_off[3:2]);
  assign stage       = frame_stage_e'(cmd_off[1:0]);
  assign r1_seen     = (miso != BYTE_IDLE);
  assign multi_new   = (item_i.block_count > 8'd1);

  always_comb begin
    phase_d     = phase_q;
    frame_d     = frame_q;
    bytepos_d   = bytepos_q;
    blocks_d    = blocks_q;
    poll_d      = poll_q;
    card_addr_d = card_addr_q;
    writing_d   = writing_q;
    multi_d     = multi_q;
    res_o       = '0;
    res_o.chip_select_n = 1'b1;
    res_o.status        = ST_BUSY;

    if (!item_i.mode) begin
      // New request: any transfer in flight is dropped.
      writing_d = item_i.write_request;
      blocks_d  = item_i.block_count;
      multi_d   = multi_new;
      bytepos_d = '0;
      frame_d   = '0;
      poll_d    = '0;
      if (item_i.block_count == 8'd0) begin
        phase_d = PH_IDLE;
        res_o   = finish(ST_CMD_REJ);
      end else begin
        card_addr_d = (cfg_i.card_type == CT_SD2_HC) ? item_i.block_addr
                                                      : {item_i.block_addr[22:0], 9'd0};
        if (item_i.write_request && multi_new && cfg_i.card_type != CT_MMC) begin
          phase_d = PH_SETC_SEL;
        end else begin
          phase_d = PH_MAIN_SEL;
        end
        res_o = xfer(BYTE_IDLE, 1'b1);
      end
    end else if (phase_q == PH_IDLE) begin
      res_o = res_o;
    end else if (phase_q inside {[PH_MAIN_SEL:PH_STOP_R1]}) begin
      case (stage)
        FS_SELECT: begin
          phase_d = phase_e'(phase_q + 5'd1);
          poll_d  = '0;
          res_o   = xfer(BYTE_IDLE, 1'b0);
        end
        FS_READY: begin
          if (miso == BYTE_IDLE) begin
            phase_d = phase_e'(phase_q + 5'd1);
            frame_d = '0;
            res_o   = xfer(frame_byte(kind, 3'd0, writing_q, multi_q, blocks_q, card_addr_q),
                           1'b0);
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= cfg_i.ready_timeout) begin
              phase_d = PH_IDLE;
              res_o   = finish(ST_TIMEOUT);
            end else begin
              res_o = xfer(BYTE_IDLE, 1'b0);
            end
          end
        end
        FS_FRAME: begin
          frame_d = frame_inc;
          if (frame_inc < FRAME_BYTES) begin
            res_o = xfer(frame_byte(kind, frame_inc, writing_q, multi_q, blocks_q, card_addr_q),
                         1'b0);
          end else begin
            phase_d = phase_e'(phase_q + 5'd1);
            frame_d = '0;
            poll_d  = '0;
            res_o   = xfer(BYTE_IDLE, 1'b0);
          end
        end
        default: begin
          if (!r1_seen) begin
            poll_d = poll_inc;
          end
          if (r1_seen || poll_inc >= RESP_POLL_LIMIT) begin
            case (kind)
              K_SETCOUNT: begin
                // The count command's R1 is ignored; the write command follows.
                phase_d = PH_MAIN_SEL;
                poll_d  = '0;
                frame_d = '0;
                res_o   = xfer(BYTE_IDLE, 1'b1);
              end
              K_STOP: begin
                phase_d = PH_TAIL;
                res_o   = xfer(BYTE_IDLE, 1'b1);
              end
              default: begin
                if (!r1_seen) begin
                  phase_d = PH_IDLE;
                  res_o   = finish(ST_TIMEOUT);
                end else if (miso != 8'd0) begin
                  phase_d = PH_IDLE;
                  res_o   = finish(ST_CMD_REJ);
                end else begin
                  poll_d    = '0;
                  bytepos_d = '0;
                  phase_d   = writing_q ? PH_WR_FILL : PH_RD_TOKEN;
                  res_o     = xfer(BYTE_IDLE, 1'b0);
                end
              end
            endcase
          end else begin
            res_o = xfer(BYTE_IDLE, 1'b0);
          end
        end
      endcase
    end else begin
      case (phase_q)
        PH_RD_TOKEN: begin
          if (miso == TOKEN_SINGLE) begin
            phase_d   = PH_RD_DATA;
            bytepos_d = '0;
            res_o     = xfer(BYTE_IDLE, 1'b0);
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= cfg_i.token_timeout) begin
              phase_d = PH_IDLE;
              res_o   = finish(ST_TIMEOUT);
            end else begin
              res_o = xfer(BYTE_IDLE, 1'b0);
            end
          end
        end
        PH_RD_DATA: begin
          bytepos_d = bytepos_inc;
          if (bytepos_inc >= BLOCK_BYTES) begin
            phase_d   = PH_RD_CRC;
            bytepos_d = '0;
          end
          res_o            = xfer(BYTE_IDLE, 1'b0);
          res_o.read_valid = 1'b1;
          res_o.read_byte  = miso;
        end
        PH_RD_CRC: begin
          bytepos_d = bytepos_inc;
          if (bytepos_inc < 10'd2) begin
            res_o = xfer(BYTE_IDLE, 1'b0);
          end else begin
            bytepos_d = '0;
            blocks_d  = blocks_dec;
            if (blocks_dec != 8'd0) begin
              phase_d = PH_RD_TOKEN;
              poll_d  = '0;
              res_o   = xfer(BYTE_IDLE, 1'b0);
            end else if (!multi_q) begin
              phase_d = PH_IDLE;
              res_o   = finish(ST_DONE);
            end else begin
              phase_d = PH_STOP_SEL;
              poll_d  = '0;
              frame_d = '0;
              res_o   = xfer(BYTE_IDLE, 1'b1);
            end
          end
        end
        PH_WR_FILL: begin
          bytepos_d = bytepos_inc;
          if (bytepos_inc < (multi_q ? 10'd2 : 10'd3)) begin
            res_o = xfer(BYTE_IDLE, 1'b0);
          end else begin
            phase_d   = PH_WR_TOKEN;
            bytepos_d = '0;
            res_o     = xfer(multi_q ? TOKEN_MULTI : TOKEN_SINGLE, 1'b0);
          end
        end
        PH_WR_TOKEN: begin
          phase_d               = PH_WR_DATA;
          bytepos_d             = '0;
          res_o                 = xfer(item_i.write_byte, 1'b0);
          res_o.payload_request = 1'b1;
        end
        PH_WR_DATA: begin
          bytepos_d = bytepos_inc;
          if (bytepos_inc < BLOCK_BYTES) begin
            res_o                 = xfer(item_i.write_byte, 1'b0);
            res_o.payload_request = 1'b1;
          end else begin
            phase_d   = PH_WR_CRC;
            bytepos_d = '0;
            res_o     = xfer(BYTE_IDLE, 1'b0);
          end
        end
        PH_WR_CRC: begin
          bytepos_d = bytepos_inc;
          if (bytepos_inc >= 10'd2) begin
            phase_d   = PH_WR_RESP;
            bytepos_d = '0;
          end
          res_o = xfer(BYTE_IDLE, 1'b0);
        end
        PH_WR_RESP: begin
          if ((miso & DRESP_MASK) != DRESP_ACCEPTED) begin
            phase_d = PH_IDLE;
            res_o   = finish(ST_DATA_REJ);
          end else begin
            phase_d = PH_WR_BUSY;
            poll_d  = '0;
            res_o   = xfer(BYTE_IDLE, 1'b0);
          end
        end
        PH_WR_BUSY: begin
          // A single write is done on any nonzero reply, a multi write on 0xFF.
          if (multi_q ? (miso != BYTE_IDLE) : (miso == 8'd0)) begin
            poll_d = poll_inc;
            if (poll_inc >= {4'd0, cfg_i.busy_timeout}) begin
              phase_d = PH_IDLE;
              res_o   = finish(ST_TIMEOUT);
            end else begin
              res_o = xfer(BYTE_IDLE, 1'b0);
            end
          end else begin
            blocks_d = blocks_dec;
            if (!multi_q) begin
              phase_d = PH_TAIL;
              res_o   = xfer(BYTE_IDLE, 1'b1);
            end else if (blocks_dec != 8'd0) begin
              phase_d = PH_WR_TOKEN;
              res_o   = xfer(TOKEN_MULTI, 1'b0);
            end else begin
              phase_d = PH_WR_STOP;
              res_o   = xfer(TOKEN_STOP, 1'b0);
            end
          end
        end
        PH_WR_STOP: begin
          phase_d = PH_WR_STOPWAIT;
          poll_d  = '0;
          res_o   = xfer(BYTE_IDLE, 1'b0);
        end
        PH_WR_STOPWAIT: begin
          if (miso == BYTE_IDLE) begin
            phase_d = PH_TAIL;
            res_o   = xfer(BYTE_IDLE, 1'b1);
          end else begin
            poll_d = poll_inc;
            if (poll_inc >= {4'd0, cfg_i.busy_timeout}) begin
              phase_d = PH_IDLE;
              res_o   = finish(ST_TIMEOUT);
            end else begin
              res_o = xfer(BYTE_IDLE, 1'b0);
            end
          end
        end
        PH_TAIL: begin
          phase_d = PH_IDLE;
          res_o   = finish(ST_DONE);
        end
        default: begin
          phase_d = PH_IDLE;
          res_o   = finish(ST_TIMEOUT);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      frame_q     <= '0;
      bytepos_q   <= '0;
      blocks_q    <= '0;
      poll_q      <= '0;
      card_addr_q <= '0;
      writing_q   <= 1'b0;
      multi_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      frame_q     <= frame_d;
      bytepos_q   <= bytepos_d;
      blocks_q    <= blocks_d;
      poll_q      <= poll_d;
      card_addr_q <= card_addr_d;
      writing_q   <= writing_d;
      multi_q     <= multi_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sd_spi_block_transfer_engine.sv
// Top level of the SD SPI-mode block read/write sequencer.
//
// Usage: a request (mode 0) starts a read or write of block_count blocks at
// block_addr. Each result names the next SPI byte exchange (send_valid,
// mosi_byte, chip_select_n); the byte received in that exchange is then fed
// back as an item with mode 1. During write data the item's write_byte is
// sent and payload_request marks it; during read data read_valid/read_byte
// carry the received block bytes. done_res marks the last result of a
// transfer, with status telling how it ended.
// Every accepted item gives exactly one result. An item is captured in an
// input register and its result is computed from there into the output
// register, so one item can be taken every cycle while the output is not stalled.
// When out_stall_i holds the result, the waiting item stays in the input
// register and in_stall_o rises until the result is taken.
// Reset returns the sequencer to idle with no result pending and loads the
// configuration registers with their defaults. The user must write configuration
// only while no transfer item is in flight; the block itself does not enforce this.
`default_nettype none

module sd_spi_block_transfer_engine
  import sdbt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic        write_request_i,
  input  wire logic [31:0] block_addr_i,
  input  wire logic [7:0]  block_count_i,
  input  wire logic [7:0]  miso_byte_i,
  input  wire logic [7:0]  write_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             send_valid_o,
  output logic [7:0]       mosi_byte_o,
  output logic             chip_select_n_o,
  output logic             payload_request_o,
  output logic             read_valid_o,
  output logic [7:0]       read_byte_o,
  output logic [2:0]       status_o,
  output logic             done_res_o
);

  cfg_t     cfg;
  in_item_t in_q;
  logic     in_valid_q, in_valid_d;
  res_t     res, out_q;
  logic     out_valid_q, out_valid_d;
  logic     out_load;
  logic     step;
  logic     in_accept;

  sdbt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sdbt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_load   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_load;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.mode          <= mode_i;
      in_q.write_request <= write_request_i;
      in_q.block_addr    <= block_addr_i;
      in_q.block_count   <= block_count_i;
      in_q.miso_byte     <= miso_byte_i;
      in_q.write_byte    <= write_byte_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_valid_o      = out_q.send_valid;
  assign mosi_byte_o       = out_q.mosi_byte;
  assign chip_select_n_o   = out_q.chip_select_n;
  assign payload_request_o = out_q.payload_request;
  assign read_valid_o      = out_q.read_valid;
  assign read_byte_o       = out_q.read_byte;
  assign status_o          = out_q.status;
  assign done_res_o        = out_q.done_res;

endmodule

`default_nettype wire

FILE: rtl/sdbt_checker.sv
// Port-level assertions for the SD SPI block transfer engine, bound to the top.
`default_nettype none

module sdbt_checker
  import sdbt_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       send_valid_o,
  input wire logic [7:0] mosi_byte_o,
  input wire logic       chip_select_n_o,
  input wire logic       payload_request_o,
  input wire logic       read_valid_o,
  input wire logic [2:0] status_o,
  input wire logic       done_res_o
);

  // A stalled result keeps its exchange byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mosi_byte_o)
                                   && $stable(send_valid_o))
    else $error("stalled result changed");

  // No exchange means the card is deselected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> chip_select_n_o)
    else $error("card selected without an exchange");

  // Payload bytes in either direction only move with the card selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (payload_request_o || read_valid_o)
      |-> send_valid_o && !chip_select_n_o && !done_res_o)
    else $error("data byte outside a selected exchange");

  // The last result of a transfer carries a final status and no exchange.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !send_valid_o && (status_o != ST_BUSY))
    else $error("transfer end without final status");

  // Final status only appears on the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_BUSY) |-> done_res_o)
    else $error("final status before end of transfer");

endmodule

bind sd_spi_block_transfer_engine sdbt_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .send_valid_o      (send_valid_o),
  .mosi_byte_o       (mosi_byte_o),
  .chip_select_n_o   (chip_select_n_o),
  .payload_request_o (payload_request_o),
  .read_valid_o      (read_valid_o),
  .status_o          (status_o),
  .done_res_o        (done_res_o)
);

`default_nettype wire

FILE: tb/sv/sd_spi_block_transfer_engine_test.sv
// Self-checking testbench for the SD SPI block transfer engine, with card emulation.
module sd_spi_block_transfer_engine_test
  import sdbt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned TRANSFER_CAP = 1200;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    in_item_t item;
    logic     typed;
    res_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic        write_request = 1'b0;
  logic [31:0] block_addr = '0;
  logic [7:0]  block_count = '0;
  logic [7:0]  miso_byte = '0;
  logic [7:0]  write_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        send_valid;
  logic [7:0]  mosi_byte;
  logic        chip_select_n;
  logic        payload_request;
  logic        read_valid;
  logic [7:0]  read_byte;
  logic [2:0]  status;
  logic        done_res;

  sd_spi_block_transfer_engine dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .write_request_i   (write_request),
    .block_addr_i      (block_addr),
    .block_count_i     (block_count),
    .miso_byte_i       (miso_byte),
    .write_byte_i      (write_byte),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .send_valid_o      (send_valid),
    .mosi_byte_o       (mosi_byte),
    .chip_select_n_o   (chip_select_n),
    .payload_request_o (payload_request),
    .read_valid_o      (read_valid),
    .read_byte_o       (read_byte),
    .status_o          (status),
    .done_res_o        (done_res)
  );

  always #10 clk = ~clk;

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned item_budget = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned status_seen [5];
  logic        steady;
  logic        silent_card = 1'b0;
  res_t        pending_exchanges [$];
  stim_row_t   rows [$];

  // Both sides stop idling inside this window.
  assign steady = (cycles >= 500) && (cycles < 900);

  // Copy of the engine state and its registers.
  card_type_e  m_card;
  logic [19:0] m_ready_to;
  logic [19:0] m_token_to;
  logic [15:0] m_busy_to;
  phase_e      m_phase;
  logic [2:0]  m_frame_pos;
  logic [9:0]  m_byte_pos;
  logic [7:0]  m_left;
  logic [19:0] m_polls;
  logic [31:0] m_addr;
  logic        m_writing;
  logic        m_multi;

  function automatic void reset_model();
    m_card = CT_MMC;
    m_ready_to = 20'hFFFFF;
    m_token_to = 20'hFFFFF;
    m_busy_to = 16'hFFFE;
    m_phase = PH_IDLE;
    m_frame_pos = '0;
    m_byte_pos = '0;
    m_left = '0;
    m_polls = '0;
    m_addr = '0;
    m_writing = 1'b0;
    m_multi = 1'b0;
  endfunction

  function automatic res_t make_res(logic sv, logic [7:0] mosi, logic csn, status_e st,
                                    logic dn);
    res_t r;
    r = '0;
    r.send_valid = sv;
    r.mosi_byte = mosi;
    r.chip_select_n = csn;
    r.status = st;
    r.done_res = dn;
    return r;
  endfunction

  function automatic res_t exchange(logic [7:0] mosi, logic csn);
    return make_res(1'b1, mosi, csn, ST_BUSY, 1'b0);
  endfunction

  function automatic res_t end_transfer(status_e st);
    m_phase = PH_IDLE;
    return make_res(1'b0, 8'h00, 1'b1, st, 1'b1);
  endfunction

  // The poll counter saturates, and a limit of zero behaves like one.
  function automatic logic poll_expired(logic [19:0] limit);
    if (m_polls < POLL_MAX) m_polls = m_polls + 20'd1;
    return m_polls >= limit;
  endfunction

  function automatic logic [7:0] frame_byte(cmd_kind_e kind, logic [2:0] pos);
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    case (kind)
      K_SETCOUNT: begin
        cmd = CMD23;
        arg = {24'h0, m_left};
        crc = CRC_SETCNT;
      end
      K_STOP: begin
        cmd = CMD12;
        arg = '0;
        crc = CRC_MULTI;
      end
      default: begin
        if (m_writing) cmd = m_multi ? CMD25 : CMD24;
        else cmd = m_multi ? CMD18 : CMD17;
        crc = m_multi ? CRC_MULTI : CRC_SINGLE;
        arg = m_addr;
      end
    endcase
    if (pos == 3'd0) return CMD_PREFIX | {2'b00, cmd};
    if (pos <= 3'd4) return 8'(arg >> (8 * (4 - pos)));
    return crc;
  endfunction

  function automatic res_t start_frame(cmd_kind_e kind);
    m_phase = phase_e'(5'(PH_MAIN_SEL) + 5'({kind, 2'b00}));
    m_polls = '0;
    m_frame_pos = '0;
    return exchange(BYTE_IDLE, 1'b1);
  endfunction

  function automatic res_t after_r1(cmd_kind_e kind, logic [7:0] r1, logic answered);
    if (kind == K_SETCOUNT) return start_frame(K_MAIN);
    if (kind == K_STOP) begin
      m_phase = PH_TAIL;
      return exchange(BYTE_IDLE, 1'b1);
    end
    if (!answered) return end_transfer(ST_TIMEOUT);
    if (r1 != 8'h00) return end_transfer(ST_CMD_REJ);
    m_polls = '0;
    m_byte_pos = '0;
    m_phase = m_writing ? PH_WR_FILL : PH_RD_TOKEN;
    return exchange(BYTE_IDLE, 1'b0);
  endfunction

  function automatic res_t frame_step(logic [7:0] miso);
    logic [4:0]   offs;
    cmd_kind_e    kind;
    frame_stage_e stage;
    offs = m_phase - PH_MAIN_SEL;
    kind = cmd_kind_e'(offs[3:2]);
    stage = frame_stage_e'(offs[1:0]);
    case (stage)
      FS_SELECT: begin
        m_phase = phase_e'(m_phase + 5'd1);
        m_polls = '0;
        return exchange(BYTE_IDLE, 1'b0);
      end
      FS_READY: begin
        if (miso == BYTE_IDLE) begin
          m_phase = phase_e'(m_phase + 5'd1);
          m_frame_pos = '0;
          return exchange(frame_byte(kind, 3'd0), 1'b0);
        end
        if (poll_expired(m_ready_to)) return end_transfer(ST_TIMEOUT);
        return exchange(BYTE_IDLE, 1'b0);
      end
      FS_FRAME: begin
        m_frame_pos = m_frame_pos + 3'd1;
        if (m_frame_pos < FRAME_BYTES) return exchange(frame_byte(kind, m_frame_pos), 1'b0);
        m_phase = phase_e'(m_phase + 5'd1);
        m_frame_pos = '0;
        m_polls = '0;
        return exchange(BYTE_IDLE, 1'b0);
      end
      default: begin
        if (miso != BYTE_IDLE) return after_r1(kind, miso, 1'b1);
        if (poll_expired(RESP_POLL_LIMIT)) return after_r1(kind, BYTE_IDLE, 1'b0);
        return exchange(BYTE_IDLE, 1'b0);
      end
    endcase
  endfunction

  function automatic res_t next_exchange(in_item_t it);
    res_t r;
    if (!it.mode) begin
      m_writing = it.write_request;
      m_left = it.block_count;
      m_multi = m_left > 8'd1;
      m_byte_pos = '0;
      m_frame_pos = '0;
      m_polls = '0;
      if (m_left == 8'd0) return end_transfer(ST_CMD_REJ);
      // Standard-capacity cards take a byte address.
      m_addr = (m_card == CT_SD2_HC) ? it.block_addr : {it.block_addr[22:0], 9'h000};
      if (m_writing && m_multi && m_card != CT_MMC) return start_frame(K_SETCOUNT);
      return start_frame(K_MAIN);
    end
    if (m_phase == PH_IDLE) return make_res(1'b0, 8'h00, 1'b1, ST_BUSY, 1'b0);
    if (m_phase <= PH_STOP_R1) return frame_step(it.miso_byte);
    case (m_phase)
      PH_RD_TOKEN: begin
        if (it.miso_byte == TOKEN_SINGLE) begin
          m_phase = PH_RD_DATA;
          m_byte_pos = '0;
          return exchange(BYTE_IDLE, 1'b0);
        end
        if (poll_expired(m_token_to)) return end_transfer(ST_TIMEOUT);
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_RD_DATA: begin
        m_byte_pos = m_byte_pos + 10'd1;
        if (m_byte_pos >= BLOCK_BYTES) begin
          m_phase = PH_RD_CRC;
          m_byte_pos = '0;
        end
        r = exchange(BYTE_IDLE, 1'b0);
        r.read_valid = 1'b1;
        r.read_byte = it.miso_byte;
        return r;
      end
      PH_RD_CRC: begin
        m_byte_pos = m_byte_pos + 10'd1;
        if (m_byte_pos < 10'd2) return exchange(BYTE_IDLE, 1'b0);
        m_byte_pos = '0;
        if (m_left != 8'd0) m_left = m_left - 8'd1;
        if (m_left != 8'd0) begin
          m_phase = PH_RD_TOKEN;
          m_polls = '0;
          return exchange(BYTE_IDLE, 1'b0);
        end
        if (!m_multi) return end_transfer(ST_DONE);
        return start_frame(K_STOP);
      end
      PH_WR_FILL: begin
        m_byte_pos = m_byte_pos + 10'd1;
        if (m_byte_pos < (m_multi ? 10'd2 : 10'd3)) return exchange(BYTE_IDLE, 1'b0);
        m_phase = PH_WR_TOKEN;
        m_byte_pos = '0;
        return exchange(m_multi ? TOKEN_MULTI : TOKEN_SINGLE, 1'b0);
      end
      PH_WR_TOKEN: begin
        m_phase = PH_WR_DATA;
        m_byte_pos = '0;
        r = exchange(it.write_byte, 1'b0);
        r.payload_request = 1'b1;
        return r;
      end
      PH_WR_DATA: begin
        m_byte_pos = m_byte_pos + 10'd1;
        if (m_byte_pos < BLOCK_BYTES) begin
          r = exchange(it.write_byte, 1'b0);
          r.payload_request = 1'b1;
          return r;
        end
        m_phase = PH_WR_CRC;
        m_byte_pos = '0;
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_WR_CRC: begin
        m_byte_pos = m_byte_pos + 10'd1;
        if (m_byte_pos >= 10'd2) begin
          m_phase = PH_WR_RESP;
          m_byte_pos = '0;
        end
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_WR_RESP: begin
        if ((it.miso_byte & DRESP_MASK) != DRESP_ACCEPTED) return end_transfer(ST_DATA_REJ);
        m_phase = PH_WR_BUSY;
        m_polls = '0;
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_WR_BUSY: begin
        // A single write is busy while the card returns zero, a multi write until 0xFF.
        if (m_multi ? (it.miso_byte != BYTE_IDLE) : (it.miso_byte == 8'h00)) begin
          if (poll_expired({4'h0, m_busy_to})) return end_transfer(ST_TIMEOUT);
          return exchange(BYTE_IDLE, 1'b0);
        end
        if (m_left != 8'd0) m_left = m_left - 8'd1;
        if (!m_multi) begin
          m_phase = PH_TAIL;
          return exchange(BYTE_IDLE, 1'b1);
        end
        if (m_left != 8'd0) begin
          m_phase = PH_WR_TOKEN;
          return exchange(TOKEN_MULTI, 1'b0);
        end
        m_phase = PH_WR_STOP;
        return exchange(TOKEN_STOP, 1'b0);
      end
      PH_WR_STOP: begin
        m_phase = PH_WR_STOPWAIT;
        m_polls = '0;
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_WR_STOPWAIT: begin
        if (it.miso_byte == BYTE_IDLE) begin
          m_phase = PH_TAIL;
          return exchange(BYTE_IDLE, 1'b1);
        end
        if (poll_expired({4'h0, m_busy_to})) return end_transfer(ST_TIMEOUT);
        return exchange(BYTE_IDLE, 1'b0);
      end
      PH_TAIL: return end_transfer(ST_DONE);
      default: return end_transfer(ST_TIMEOUT);
    endcase
  endfunction

  function automatic logic roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Answers the card would give to the exchange that the engine just asked for.
  function automatic logic [7:0] card_reply();
    logic [7:0] b;
    b = 8'($urandom);
    case (m_phase)
      PH_MAIN_READY, PH_SETC_READY, PH_STOP_READY:
        b = roll(70) ? BYTE_IDLE : 8'($urandom_range(0, 254));
      PH_MAIN_R1: begin
        if (silent_card || roll(35)) b = BYTE_IDLE;
        else if (roll(90)) b = 8'h00;
        else b = 8'($urandom_range(1, 254));
      end
      PH_SETC_R1, PH_STOP_R1: if (roll(40)) b = BYTE_IDLE;
      PH_RD_TOKEN: if (roll(65)) b = TOKEN_SINGLE;
      PH_WR_RESP: if (roll(88)) b = {b[7:5], 5'h05};
      PH_WR_BUSY: begin
        if (m_multi) b = roll(60) ? BYTE_IDLE : 8'($urandom_range(0, 254));
        else b = roll(55) ? 8'($urandom_range(1, 255)) : 8'h00;
      end
      PH_WR_STOPWAIT: b = roll(60) ? BYTE_IDLE : 8'($urandom_range(0, 254));
      default: ;
    endcase
    return b;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("sv=%0b mosi=%02h csn=%0b pay=%0b rv=%0b rb=%02h st=%0d done=%0b",
                     r.send_valid, r.mosi_byte, r.chip_select_n, r.payload_request,
                     r.read_valid, r.read_byte, r.status, r.done_res);
  endfunction

  function automatic stim_row_t row(logic md, logic wr, logic [31:0] addr, logic [7:0] cnt,
                                    logic [7:0] miso, logic [7:0] wb, logic typed, res_t want);
    stim_row_t s;
    s.item.mode = md;
    s.item.write_request = wr;
    s.item.block_addr = addr;
    s.item.block_count = cnt;
    s.item.miso_byte = miso;
    s.item.write_byte = wb;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic drive_request(in_item_t it, logic typed, res_t want);
    res_t predicted;
    @(negedge clk);
    while (!steady && roll(IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    write_request <= it.write_request;
    block_addr <= it.block_addr;
    block_count <= it.block_count;
    miso_byte <= it.miso_byte;
    write_byte <= it.write_byte;
    do @(posedge clk); while (in_stall);
    predicted = next_exchange(it);
    pending_exchanges.push_back(typed ? want : predicted);
    items_sent++;
    if (!it.mode) requests_sent++;
  endtask

  task automatic exchange_item(logic [7:0] miso);
    in_item_t it;
    it.mode = 1'b1;
    it.write_request = 1'($urandom);
    it.block_addr = $urandom;
    it.block_count = 8'($urandom);
    it.miso_byte = miso;
    it.write_byte = 8'($urandom);
    drive_request(it, 1'b0, '0);
  endtask

  // One request followed by the card's side of the exchanges it causes.
  task automatic run_transfer();
    in_item_t    it;
    int unsigned n;
    int unsigned pick;
    it.mode = 1'b0;
    it.write_request = 1'($urandom);
    it.block_addr = $urandom;
    it.miso_byte = 8'($urandom);
    it.write_byte = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) it.block_count = 8'd0;
    else if (pick < 62) it.block_count = 8'd1;
    else if (pick < 93) it.block_count = 8'($urandom_range(2, 3));
    else it.block_count = 8'($urandom);
    silent_card = roll(4);
    drive_request(it, 1'b0, '0);
    n = 0;
    // A transfer still open when the item budget runs out is dropped by the next request.
    while (m_phase != PH_IDLE && n < TRANSFER_CAP && items_sent < item_budget) begin
      // Now and then leave the transfer open so the next request cuts it off.
      if ($urandom_range(0, 599) == 0) break;
      exchange_item(card_reply());
      n++;
    end
    if (roll(20)) repeat ($urandom_range(1, 3)) exchange_item(8'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_exchanges.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [19:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CARD_TYPE: m_card = card_type_e'(d[1:0]);
      CFG_READY_TO:  m_ready_to = d;
      CFG_TOKEN_TO:  m_token_to = d;
      default:       m_busy_to = d[15:0];
    endcase
  endtask

  task automatic apply_settings(card_type_e ct, logic [19:0] rdy, logic [19:0] tok,
                                logic [15:0] bsy);
    write_cfg(CFG_CARD_TYPE, 20'(ct));
    write_cfg(CFG_READY_TO, rdy);
    write_cfg(CFG_TOKEN_TO, tok);
    write_cfg(CFG_BUSY_TO, {4'h0, bsy});
  endtask

  always @(negedge clk) out_stall <= !steady && roll(IDLE_PCT);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_exchanges.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  res_t got;
  res_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '0;
      got.send_valid = send_valid;
      got.mosi_byte = mosi_byte;
      got.chip_select_n = chip_select_n;
      got.payload_request = payload_request;
      got.read_valid = read_valid;
      got.read_byte = read_byte;
      got.status = status_e'(status);
      got.done_res = done_res;
      if (pending_exchanges.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX) $display("cycle %0d: unexpected result %s", cycles, show(got));
      end else begin
        want = pending_exchanges.pop_front();
        results_checked++;
        if (int'(want.status) < 5) status_seen[int'(want.status)]++;
        if (got !== want) begin
          failures++;
          if (failures <= REPORT_MAX) begin
            $display("cycle %0d: expected %s", cycles, show(want));
            $display("cycle %0d:      got %s", cycles, show(got));
          end
        end
      end
    end
  end

  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    reset_model();

    // Directed part, under the reset register values (MMC, ready/token timeouts 0xFFFFF, busy 0xFFFE).
    rows.push_back(row(1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                       make_res(1'b0, 8'h00, 1'b1, ST_BUSY, 1'b0)));
    rows.push_back(row(1'b0, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1,
                       make_res(1'b0, 8'h00, 1'b1, ST_CMD_REJ, 1'b1)));
    rows.push_back(row(1'b0, 1'b1, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'hFF, 1'b1,
                       make_res(1'b0, 8'h00, 1'b1, ST_CMD_REJ, 1'b1)));
    rows.push_back(row(1'b0, 1'b0, 32'hFFFF_FFFF, 8'h01, 8'h00, 8'h00, 1'b1,
                       make_res(1'b1, BYTE_IDLE, 1'b1, ST_BUSY, 1'b0)));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1,
                       make_res(1'b1, BYTE_IDLE, 1'b0, ST_BUSY, 1'b0)));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'hFF, 8'h00, 1'b1,
                       make_res(1'b1, CMD_PREFIX | {2'b00, CMD17}, 1'b0, ST_BUSY, 1'b0)));
    repeat (5) rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'hA5, 8'h5A, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'hFF, 8'h00, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'h01, 8'h00, 1'b1,
                       make_res(1'b0, 8'h00, 1'b1, ST_CMD_REJ, 1'b1)));
    rows.push_back(row(1'b0, 1'b1, 32'h0, 8'hFF, 8'h00, 8'h00, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'hFF, 8'hFF, 1'b0, '0));
    // A new request while the write above is still running.
    rows.push_back(row(1'b0, 1'b0, 32'h0012_3456, 8'h02, 8'h00, 8'h00, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b1, 32'h0, 8'h00, 8'h7E, 8'h00, 1'b0, '0));
    rows.push_back(row(1'b1, 1'b0, 32'h0, 8'h00, 8'hFF, 8'hFF, 1'b0, '0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) drive_request(rows[i].item, rows[i].typed, rows[i].want);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: apply_settings(CT_MMC, 20'd1, 20'd1, 16'd1);
        1: apply_settings(CT_SD1, 20'd4, 20'd8, 16'd6);
        2: apply_settings(CT_SD2_SC, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        3: apply_settings(CT_SD2_HC, 20'd3, 20'd40, 16'd3);
        default: apply_settings(CT_SD2_HC, 20'd0, 20'd0, 16'd0);
      endcase
      // The setting with the widest timeouts gets room for a whole block.
      item_budget = items_sent + ((p == 2) ? 4 * PHASE_ITEMS : PHASE_ITEMS);
      while (items_sent < item_budget) run_transfer();
    end

    settle();
    repeat (4) @(posedge clk);
    if (pending_exchanges.size() != 0) failures++;

    $display("Run covered %0d requests in %0d items under five register settings, %0d checked.",
             requests_sent, items_sent, results_checked);
    $display("Transfer ends: %0d done, %0d cmd rejected, %0d data rejected, %0d timed out.",
             status_seen[int'(ST_DONE)], status_seen[int'(ST_CMD_REJ)],
             status_seen[int'(ST_DATA_REJ)], status_seen[int'(ST_TIMEOUT)]);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", failures);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
